// ----- rtl/core/pmmq_pkg.sv -----
// Package: shared types and codes of the pending message match queue.
`timescale 1ns / 1ps

package pmmq_pkg;

  localparam int unsigned COMM_W   = 6;
  localparam int unsigned RANK_W   = 16;
  localparam int unsigned TAG_W    = 15;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COMM_SPAN = 2 ** COMM_W;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 48;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_FIND  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED    = 3'd0,
    STAT_FOUND     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_NO_COMM   = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic [COMM_W-1:0]   comm;
    logic [TAG_W-1:0]    tag;
    logic [RANK_W-1:0]   source;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    op_e                 op;
    logic [COMM_W-1:0]   comm;
    logic [RANK_W-1:0]   source;
    logic                any_source;
    logic [TAG_W-1:0]    tag;
    logic                any_tag;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [RANK_W-1:0]   source;
    logic [TAG_W-1:0]    tag;
  } res_t;

endpackage

// ----- rtl/core/pmmq_engine.sv -----
// Engine: entry memory, scan and compaction sequencer of the match queue.
`timescale 1ns / 1ps

module pmmq_engine #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned COMM_COUNT  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COMM_COUNT-1:0] mask_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  pmmq_pkg::req_t        req_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output pmmq_pkg::res_t        res_o
);

  import pmmq_pkg::*;

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  req_t              req_q;
  res_t              res_q, res_d;
  entry_t            mem_q [QUEUE_DEPTH];
  entry_t            rd_data_q;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;
  logic [COMM_SPAN-1:0] mask_ext;
  logic              hit;
  logic [CntW-1:0]   next1;
  logic [CntW-1:0]   next2;
  entry_t            new_entry;

  assign mask_ext = COMM_SPAN'(mask_i);
  assign next1 = CntW'(idx_q) + CntW'(1);
  assign next2 = CntW'(idx_q) + CntW'(2);

  assign hit = (rd_data_q.comm == req_q.comm) &&
               (req_q.any_source || (rd_data_q.source == req_q.source)) &&
               (req_q.any_tag || (rd_data_q.tag == req_q.tag));

  assign new_entry = '{comm: req_i.comm, tag: req_i.tag, source: req_i.source,
                       handle: req_i.handle};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_entry;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          res_d = '{status: STAT_NOT_FOUND, handle: '0, source: '0, tag: '0};
          if (req_i.op == OP_FIND) begin
            if (count_q == '0) begin
              state_d = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              idx_d   = '0;
              state_d = ST_SCAN;
            end
          end else begin
            state_d = ST_DONE;
            if (!mask_ext[req_i.comm]) begin
              res_d.status = STAT_NO_COMM;
            end else if (count_q == CntW'(QUEUE_DEPTH)) begin
              res_d.status = STAT_FULL;
            end else begin
              wr_en        = 1'b1;
              wr_addr      = count_q[IdxW-1:0];
              count_d      = count_q + CntW'(1);
              res_d.status = STAT_STORED;
            end
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_d = '{status: STAT_FOUND, handle: rd_data_q.handle,
                    source: rd_data_q.source, tag: rd_data_q.tag};
          if (next1 < count_q) begin
            rd_en   = 1'b1;
            rd_addr = next1[IdxW-1:0];
            state_d = ST_SHIFT;
          end else begin
            count_d = count_q - CntW'(1);
            state_d = ST_DONE;
          end
        end else if (next1 < count_q) begin
          rd_en   = 1'b1;
          rd_addr = next1[IdxW-1:0];
          idx_d   = next1[IdxW-1:0];
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data_q;
        idx_d   = next1[IdxW-1:0];
        if (next2 < count_q) begin
          rd_en   = 1'b1;
          rd_addr = next2[IdxW-1:0];
        end else begin
          count_d = count_q - CntW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

// ----- rtl/core/pending_message_match_queue.sv -----
// Top level: stream ports, communicator mask register and result register.
`timescale 1ns / 1ps

// Queue of pending messages in arrival order, held in a single-port-read
// memory of QUEUE_DEPTH entries. A find reads one entry per cycle from the
// oldest; a match at position k of n entries then moves the n-k-1 later
// entries up one place, one per cycle, through the one memory read port.
// A new item is taken once the previous one has reached the result
// register. The memory needs no clearing after reset.
module pending_message_match_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned COMM_COUNT  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pmmq_pkg::MASK_W-1:0]    cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // comm_index, source_rank, any_source, msg_tag, any_tag, msg_handle, pad
  input  logic [pmmq_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  logic [0:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // found_handle, found_source, found_tag, pad
  output logic [pmmq_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  // status
  output logic [pmmq_pkg::STATUS_W-1:0]  m_axis_tuser_o
);

  import pmmq_pkg::*;

  logic [COMM_COUNT-1:0] mask_q;
  req_t                  req;
  res_t                  res;
  logic                  res_valid;
  logic                  res_ready;
  logic                  out_valid_q;
  res_t                  out_q;

  assign req.op         = op_e'(s_axis_tuser_i[0]);
  assign req.comm       = s_axis_tdata_i[5:0];
  assign req.source     = s_axis_tdata_i[21:6];
  assign req.any_source = s_axis_tdata_i[22];
  assign req.tag        = s_axis_tdata_i[37:23];
  assign req.any_tag    = s_axis_tdata_i[38];
  assign req.handle     = s_axis_tdata_i[54:39];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i[COMM_COUNT-1:0];
    end
  end

  pmmq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COMM_COUNT  (COMM_COUNT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mask_i      (mask_q),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.tag, out_q.source, out_q.handle};
  assign m_axis_tuser_o  = out_q.status;

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken again while an item is in work");

  a_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != STAT_FOUND)) |-> (m_axis_tdata_o == '0))
    else $error("result fields not zero on a non-found status");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid_o)
    else $error("finished result not presented");
`endif

endmodule

// ----- bench/testbench.sv -----
// Testbench: directed and random transfers checked against a match queue predictor.
`timescale 1ns / 1ps

module testbench;
  import pmmq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned COMM_COUNT  = 64;
  localparam int unsigned PHASE_ITEMS = 330;

  logic                clk_i;
  logic                rst_n;
  logic                cfg_we = 1'b0;
  logic [MASK_W-1:0]   cfg_wdata = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [0:0]          s_tuser = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  req_t              send_queue[$];
  req_t              drive_item;
  res_t              expected_results[$];
  entry_t            held_msgs[$];
  logic [MASK_W-1:0] active_mask = '0;
  logic [COMM_W-1:0] hot_comm[4];
  logic [RANK_W-1:0] rank_pool[4] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h00A5};
  logic [TAG_W-1:0]  tag_pool[4] = '{15'h0000, 15'h0001, 15'h7FFF, 15'h0155};
  int                sender_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                mismatch_count = 0;
  int                status_seen[5] = '{0, 0, 0, 0, 0};
  int                transfers_out = 0;

  pending_message_match_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .COMM_COUNT (COMM_COUNT)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic req_t mk_req(op_e op, logic [COMM_W-1:0] comm, logic [RANK_W-1:0] source,
                                  logic any_source, logic [TAG_W-1:0] tag, logic any_tag,
                                  logic [HANDLE_W-1:0] handle);
    return '{op: op, comm: comm, source: source, any_source: any_source, tag: tag,
             any_tag: any_tag, handle: handle};
  endfunction

  function automatic logic [S_DATA_W-1:0] pack_req(req_t r);
    return {1'b0, r.handle, r.any_tag, r.tag, r.any_source, r.source, r.comm};
  endfunction

  function automatic res_t predict_match(req_t r);
    res_t res;
    int   hit;
    res = '0;
    hit = -1;
    if (r.op == OP_STORE) begin
      if (int'(r.comm) >= COMM_COUNT || !active_mask[r.comm]) begin
        res.status = STAT_NO_COMM;
      end else if (held_msgs.size() >= QUEUE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        held_msgs.push_back('{comm: r.comm, tag: r.tag, source: r.source, handle: r.handle});
        res.status = STAT_STORED;
      end
    end else begin
      for (int i = 0; i < held_msgs.size() && hit < 0; i++) begin
        if (held_msgs[i].comm == r.comm && (r.any_source || held_msgs[i].source == r.source) &&
            (r.any_tag || held_msgs[i].tag == r.tag)) begin
          hit = i;
        end
      end
      if (hit < 0) begin
        res.status = STAT_NOT_FOUND;
      end else begin
        res.status = STAT_FOUND;
        res.handle = held_msgs[hit].handle;
        res.source = held_msgs[hit].source;
        res.tag    = held_msgs[hit].tag;
        held_msgs.delete(hit);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : drive_proc
    req_t next_item;
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        expected_results.push_back(predict_match(drive_item));
      end
      if (!s_valid || s_ready) begin
        if (send_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = send_queue.pop_front();
          drive_item <= next_item;
          s_tdata    <= pack_req(next_item);
          s_tuser    <= next_item.op;
          s_valid    <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    res_t got;
    res_t want;
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_valid && m_ready) begin
        got.status = status_e'(m_tuser);
        got.handle = m_tdata[15:0];
        got.source = m_tdata[31:16];
        got.tag    = m_tdata[46:32];
        transfers_out++;
        if (m_tuser < 5) status_seen[m_tuser]++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual status %0d handle %h",
                   $time, got.status, got.handle);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display({"%0t: expected status %0d handle %h source %h tag %h, ",
                      "actual status %0d handle %h source %h tag %h"},
                     $time, want.status, want.handle, want.source, want.tag,
                     got.status, got.handle, got.source, got.tag);
          end
        end
      end
    end
  end

  task automatic push_item(req_t r);
    while (send_queue.size() >= 4) @(negedge clk_i);
    send_queue.push_back(r);
  endtask

  task automatic wait_idle();
    while (send_queue.size() > 0 || s_valid || expected_results.size() > 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    active_mask = value;
    @(negedge clk_i);
  endtask

  task automatic pick_hot_comms();
    logic [COMM_W-1:0] c;
    for (int k = 0; k < 4; k++) begin
      c = COMM_W'($urandom_range(63));
      for (int t = 0; t < 256 && !active_mask[c]; t++) c = COMM_W'($urandom_range(63));
      hot_comm[k] = c;
    end
  endtask

  task automatic push_random(int store_pct);
    req_t r;
    int   pick;
    r.op = ($urandom_range(99) < store_pct) ? OP_STORE : OP_FIND;
    r.comm = ($urandom_range(9) < 7) ? hot_comm[$urandom_range(3)] : COMM_W'($urandom_range(63));
    r.source = ($urandom_range(9) < 6) ? rank_pool[$urandom_range(3)] : RANK_W'($urandom);
    r.tag = ($urandom_range(9) < 6) ? tag_pool[$urandom_range(3)] : TAG_W'($urandom);
    r.any_source = ($urandom_range(9) < 3);
    r.any_tag = ($urandom_range(9) < 3);
    r.handle = HANDLE_W'($urandom);
    if (r.op == OP_FIND && held_msgs.size() > 0 && $urandom_range(1) == 1) begin
      pick = $urandom_range(held_msgs.size() - 1);
      r.comm   = held_msgs[pick].comm;
      r.source = held_msgs[pick].source;
      r.tag    = held_msgs[pick].tag;
    end
    push_item(r);
  endtask

  initial begin
    logic [MASK_W-1:0] phase_mask[6];
    int                phase_mode[6];
    int                phase_store[6];
    phase_mode  = '{0, 0, 1, 1, 2, 2};
    phase_store = '{75, 55, 50, 60, 40, 70};
    phase_mask = '{'1, {$urandom, $urandom}, 64'h8000_0000_0000_0001, '0,
                   {$urandom, $urandom}, '1};
    rst_n = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);
    sender_idle_pct = 19;
    recv_idle_pct   = 55;

    push_item(mk_req(OP_STORE, 6'd0, 16'h0001, 1'b0, 15'h0001, 1'b0, 16'h0001));
    push_item(mk_req(OP_FIND, 6'd0, 16'h0001, 1'b1, 15'h0001, 1'b1, 16'h0000));
    wait_idle();
    write_mask('1);
    push_item(mk_req(OP_STORE, 6'd0, 16'h0000, 1'b1, 15'h0000, 1'b1, 16'h0000));
    push_item(mk_req(OP_STORE, 6'd63, 16'hFFFF, 1'b0, 15'h7FFF, 1'b0, 16'hFFFF));
    push_item(mk_req(OP_STORE, 6'd5, 16'h1234, 1'b0, 15'h000A, 1'b0, 16'hAAAA));
    push_item(mk_req(OP_STORE, 6'd5, 16'h1234, 1'b0, 15'h000B, 1'b0, 16'h5555));
    push_item(mk_req(OP_STORE, 6'd5, 16'h0007, 1'b0, 15'h000A, 1'b0, 16'h0F0F));
    push_item(mk_req(OP_FIND, 6'd5, 16'h1234, 1'b0, 15'h000B, 1'b0, 16'hFFFF));
    push_item(mk_req(OP_FIND, 6'd5, 16'h9999, 1'b1, 15'h000A, 1'b0, 16'h0000));
    push_item(mk_req(OP_FIND, 6'd5, 16'h0007, 1'b0, 15'h7FFF, 1'b1, 16'h0000));
    push_item(mk_req(OP_FIND, 6'd5, 16'h0000, 1'b1, 15'h0000, 1'b1, 16'h0000));
    push_item(mk_req(OP_FIND, 6'd63, 16'hFFFF, 1'b0, 15'h7FFF, 1'b0, 16'h0000));
    push_item(mk_req(OP_FIND, 6'd0, 16'hFFFF, 1'b1, 15'h7FFF, 1'b1, 16'h0000));
    push_item(mk_req(OP_FIND, 6'd63, 16'hFFFF, 1'b0, 15'h7FFF, 1'b0, 16'h0000));
    push_item(mk_req(OP_STORE, 6'd9, 16'h0003, 1'b0, 15'h0003, 1'b0, 16'h0009));
    wait_idle();
    write_mask(~(64'd1 << 9));
    push_item(mk_req(OP_STORE, 6'd9, 16'h0004, 1'b0, 15'h0004, 1'b0, 16'h0010));
    push_item(mk_req(OP_FIND, 6'd9, 16'h0000, 1'b1, 15'h0000, 1'b1, 16'h0000));
    push_item(mk_req(OP_STORE, 6'd62, 16'h0020, 1'b0, 15'h0030, 1'b0, 16'h0040));
    push_item(mk_req(OP_FIND, 6'd62, 16'h0021, 1'b0, 15'h0030, 1'b0, 16'h0000));
    push_item(mk_req(OP_FIND, 6'd62, 16'h0000, 1'b1, 15'h0031, 1'b0, 16'h0000));
    push_item(mk_req(OP_FIND, 6'd62, 16'h0000, 1'b1, 15'h0000, 1'b1, 16'h0000));

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (phase_mode[p])
        0: begin
          sender_idle_pct = 19;
          recv_idle_pct   = 55;
        end
        1: begin
          sender_idle_pct = 55;
          recv_idle_pct   = 19;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct   = 0;
        end
      endcase
      write_mask(phase_mask[p]);
      pick_hot_comms();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) wait_idle();
        push_random(phase_store[p]);
      end
    end

    wait_idle();
    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
    mismatch_count += expected_results.size();
    $display("Summary: %0d results checked over 6 mask settings and three idle patterns",
             transfers_out);
    $display("Summary: stored %0d, found %0d, not found %0d, unknown comm %0d, queue full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pmmq_pkg.sv
rtl/core/pmmq_engine.sv
rtl/core/pending_message_match_queue.sv
bench/testbench.sv
